### design/obmu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the market-by-order book update unit.
// Used by the controller, the datapath and the top level; no dependencies.
package obmu_pkg;

	localparam int MAX_ORDERS = 1024;
	localparam int MAX_LEVELS = 256;
	localparam int OIDX_W     = $clog2(MAX_ORDERS);
	localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
	localparam int CNT_W      = 11;

	localparam logic [CNT_W-1:0] CNT_SAT = '1;

	localparam logic [2:0] MODE_CLEAR  = 3'd0;
	localparam logic [2:0] MODE_ADD    = 3'd1;
	localparam logic [2:0] MODE_CANCEL = 3'd2;
	localparam logic [2:0] MODE_MODIFY = 3'd3;

	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_UNKNOWN = 3'd1;
	localparam logic [2:0] STS_DUP     = 3'd2;
	localparam logic [2:0] STS_OVER    = 3'd3;
	localparam logic [2:0] STS_SIDE    = 3'd4;
	localparam logic [2:0] STS_FULL    = 3'd5;

	typedef enum logic [1:0] {
		SCAN_PRE,
		SCAN_OLD,
		SCAN_POST,
		SCAN_SWEEP
	} scan_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_PRE,
		S_CHECK,
		S_OLD,
		S_APPLY,
		S_SWEEP,
		S_POST,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic               valid;
		logic [63:0]        id;
		logic signed [63:0] price;
		logic               side;
		logic [31:0]        size;
		logic [31:0]        stamp;
	} entry_t;

	typedef struct packed {
		logic  load;
		logic  start;
		scan_t kind;
		logic  apply;
		logic  emit;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic need_old;
		logic is_clear;
		logic out_free;
	} sts_t;

endpackage

### design/obmu_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the book update unit: sequences the table scans,
// the update and the result hand-off. Depends on obmu_pkg.
module obmu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  obmu_pkg::sts_t  sts,
	output obmu_pkg::cmd_t  cmd
);
	import obmu_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.kind  = SCAN_PRE;
		in_stall  = 1'b1;
		case (state_q)
			S_INIT: begin
				if (sts.done) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					cmd.start = 1'b1;
					cmd.kind  = SCAN_PRE;
					state_nxt = S_PRE;
				end
			end
			S_PRE: begin
				if (sts.done) state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (sts.need_old) begin
					cmd.start = 1'b1;
					cmd.kind  = SCAN_OLD;
					state_nxt = S_OLD;
				end else begin
					state_nxt = S_APPLY;
				end
			end
			S_OLD: begin
				if (sts.done) state_nxt = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				cmd.start = 1'b1;
				if (sts.is_clear) begin
					cmd.kind  = SCAN_SWEEP;
					state_nxt = S_SWEEP;
				end else begin
					cmd.kind  = SCAN_POST;
					state_nxt = S_POST;
				end
			end
			S_SWEEP: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					cmd.kind  = SCAN_POST;
					state_nxt = S_POST;
				end
			end
			S_POST: begin
				if (sts.done) state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

### design/obmu_dpath.sv
`timescale 1ns / 1ps
// Datapath of the book update unit: order table memory, scan pipeline,
// accumulators, update decision and result registers. Depends on obmu_pkg.
module obmu_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  obmu_pkg::cmd_t     cmd,
	output obmu_pkg::sts_t     sts,
	input  logic [2:0]         mode,
	input  logic [63:0]        order_ref,
	input  logic               side,
	input  logic signed [63:0] price,
	input  logic [31:0]        quantity,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [2:0]         status,
	output logic               bid_valid,
	output logic signed [63:0] bid_price,
	output logic [31:0]        bid_total,
	output logic [10:0]        bid_orders,
	output logic               ask_valid,
	output logic signed [63:0] ask_price,
	output logic [31:0]        ask_total,
	output logic [10:0]        ask_orders,
	output logic [31:0]        queue_ahead
);
	import obmu_pkg::*;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	entry_t mem [MAX_ORDERS];

	logic              busy_q;
	scan_t             kind_q;
	logic [OIDX_W-1:0] cnt_q;
	logic              last_issue;
	logic              v_s1;
	logic [OIDX_W-1:0] idx_s1;
	entry_t            rd_s1;

	logic [2:0]         mode_q;
	logic [63:0]        id_q;
	logic               side_q;
	logic signed [63:0] px_q;
	logic [31:0]        qty_q;

	logic               o_found_q;
	logic [OIDX_W-1:0]  o_idx_q;
	logic               o_side_q;
	logic signed [63:0] o_price_q;
	logic [31:0]        o_size_q;
	logic [31:0]        o_stamp_q;
	logic               free_found_q;
	logic [OIDX_W-1:0]  free_idx_q;
	logic [1:0]         pxn_q;
	logic [1:0]         oldn_q;

	logic [31:0]      ctr_q;
	logic [LVL_W-1:0] bid_lvls_q;
	logic [LVL_W-1:0] ask_lvls_q;
	logic [2:0]       status_q;

	logic               bb_v_q;
	logic signed [63:0] bb_price_q;
	logic [31:0]        bb_total_q;
	logic [CNT_W-1:0]   bb_cnt_q;
	logic               ba_v_q;
	logic signed [63:0] ba_price_q;
	logic [31:0]        ba_total_q;
	logic [CNT_W-1:0]   ba_cnt_q;
	logic [31:0]        qa_q;

	logic               out_valid_q;

	logic               ev;
	logic [31:0]        age_e;
	logic [31:0]        age_o;
	logic [LVL_W-1:0]   lv_cur;
	logic               lv_full;
	logic               px_here;
	logic               px_one;
	logic               old_one;

	logic               do_add;
	logic [2:0]         ap_status;
	logic               wr_en;
	entry_t             wr_data;
	logic               lv_inc;
	logic               lv_dec;
	logic               ctr_inc;
	logic               n_found;
	logic [OIDX_W-1:0]  n_idx;
	logic               n_side;
	logic signed [63:0] n_price;
	logic [31:0]        n_size;
	logic [31:0]        n_stamp;

	assign last_issue = (cnt_q == OIDX_W'(MAX_ORDERS - 1));
	assign ev         = v_s1 && rd_s1.valid;
	assign age_e      = ctr_q - rd_s1.stamp;
	assign age_o      = ctr_q - o_stamp_q;
	assign lv_cur     = side_q ? ask_lvls_q : bid_lvls_q;
	assign lv_full    = (lv_cur == LVL_W'(MAX_LEVELS));
	assign px_here    = (pxn_q != 2'd0);
	assign px_one     = (pxn_q == 2'd1);
	assign old_one    = (oldn_q == 2'd1);

	assign sts.done     = (kind_q == SCAN_SWEEP) ? (busy_q && last_issue)
	                                             : (v_s1 && idx_s1 == OIDX_W'(MAX_ORDERS - 1));
	assign sts.need_old = (mode_q == MODE_MODIFY) && o_found_q && (o_side_q == side_q) &&
	                      (o_price_q != px_q);
	assign sts.is_clear = (mode_q == MODE_CLEAR);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_comb begin
		do_add    = 1'b0;
		ap_status = STS_OK;
		wr_en     = 1'b0;
		lv_inc    = 1'b0;
		lv_dec    = 1'b0;
		ctr_inc   = 1'b0;
		n_found   = o_found_q;
		n_idx     = o_idx_q;
		n_side    = o_side_q;
		n_price   = o_price_q;
		n_size    = o_size_q;
		n_stamp   = o_stamp_q;
		case (mode_q)
			MODE_CLEAR: begin
				n_found = 1'b0;
			end
			MODE_ADD: begin
				if (o_found_q) ap_status = STS_DUP;
				else do_add = 1'b1;
			end
			MODE_CANCEL: begin
				if (!o_found_q || o_side_q != side_q || o_price_q != px_q) begin
					ap_status = STS_UNKNOWN;
				end else if (qty_q > o_size_q) begin
					ap_status = STS_OVER;
				end else begin
					n_size = o_size_q - qty_q;
					wr_en  = 1'b1;
					if (n_size == 32'd0) begin
						n_found = 1'b0;
						lv_dec  = px_one;
					end
				end
			end
			MODE_MODIFY: begin
				if (!o_found_q) begin
					do_add = 1'b1;
				end else if (o_side_q != side_q) begin
					ap_status = STS_SIDE;
				end else if (o_price_q != px_q) begin
					if (!px_here && !old_one && lv_full) begin
						ap_status = STS_FULL;
					end else begin
						n_price = px_q;
						n_size  = qty_q;
						n_stamp = ctr_q;
						ctr_inc = 1'b1;
						wr_en   = 1'b1;
						lv_inc  = !px_here && !old_one;
						lv_dec  = px_here && old_one;
					end
				end else begin
					if (qty_q > o_size_q) begin
						n_stamp = ctr_q;
						ctr_inc = 1'b1;
					end
					n_size = qty_q;
					wr_en  = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (do_add) begin
			if (!free_found_q || (!px_here && lv_full)) begin
				ap_status = STS_FULL;
			end else begin
				n_found = 1'b1;
				n_idx   = free_idx_q;
				n_side  = side_q;
				n_price = px_q;
				n_size  = qty_q;
				n_stamp = ctr_q;
				ctr_inc = 1'b1;
				wr_en   = 1'b1;
				lv_inc  = !px_here;
			end
		end
		wr_data.valid = n_found;
		wr_data.id    = id_q;
		wr_data.price = n_price;
		wr_data.side  = n_side;
		wr_data.size  = n_size;
		wr_data.stamp = n_stamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b1;
			kind_q      <= SCAN_SWEEP;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			ctr_q       <= '0;
			bid_lvls_q  <= '0;
			ask_lvls_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= busy_q && (kind_q != SCAN_SWEEP);
			if (cmd.start) begin
				busy_q <= 1'b1;
				kind_q <= cmd.kind;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + OIDX_W'(1);
				if (last_issue) busy_q <= 1'b0;
			end
			if (cmd.apply) begin
				if (ctr_inc) ctr_q <= ctr_q + 32'd1;
				if (mode_q == MODE_CLEAR) begin
					bid_lvls_q <= '0;
					ask_lvls_q <= '0;
				end else if (side_q) begin
					if (lv_inc) ask_lvls_q <= ask_lvls_q + LVL_W'(1);
					else if (lv_dec) ask_lvls_q <= ask_lvls_q - LVL_W'(1);
				end else begin
					if (lv_inc) bid_lvls_q <= bid_lvls_q + LVL_W'(1);
					else if (lv_dec) bid_lvls_q <= bid_lvls_q - LVL_W'(1);
				end
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && kind_q == SCAN_SWEEP) begin
			mem[cnt_q] <= '0;
		end else if (cmd.apply && wr_en) begin
			mem[n_idx] <= wr_data;
		end
		rd_s1  <= mem[cnt_q];
		idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			id_q   <= order_ref;
			side_q <= side;
			px_q   <= price;
			qty_q  <= quantity;
		end

		if (cmd.start && cmd.kind == SCAN_PRE) begin
			o_found_q    <= 1'b0;
			free_found_q <= 1'b0;
			pxn_q        <= 2'd0;
		end else if (v_s1 && kind_q == SCAN_PRE) begin
			if (ev && rd_s1.id == id_q && !o_found_q) begin
				o_found_q <= 1'b1;
				o_idx_q   <= idx_s1;
				o_side_q  <= rd_s1.side;
				o_price_q <= rd_s1.price;
				o_size_q  <= rd_s1.size;
				o_stamp_q <= rd_s1.stamp;
			end
			if (!rd_s1.valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (ev && rd_s1.side == side_q && rd_s1.price == px_q && pxn_q != 2'd2) begin
				pxn_q <= pxn_q + 2'd1;
			end
		end else if (cmd.apply) begin
			o_found_q <= n_found;
			o_idx_q   <= n_idx;
			o_side_q  <= n_side;
			o_price_q <= n_price;
			o_size_q  <= n_size;
			o_stamp_q <= n_stamp;
		end

		if (cmd.apply) status_q <= ap_status;

		if (cmd.start && cmd.kind == SCAN_OLD) begin
			oldn_q <= 2'd0;
		end else if (v_s1 && kind_q == SCAN_OLD) begin
			if (ev && rd_s1.side == o_side_q && rd_s1.price == o_price_q && oldn_q != 2'd2) begin
				oldn_q <= oldn_q + 2'd1;
			end
		end

		if (cmd.start && cmd.kind == SCAN_POST) begin
			bb_v_q     <= 1'b0;
			bb_price_q <= '0;
			bb_total_q <= '0;
			bb_cnt_q   <= '0;
			ba_v_q     <= 1'b0;
			ba_price_q <= '0;
			ba_total_q <= '0;
			ba_cnt_q   <= '0;
			qa_q       <= '0;
		end else if (ev && kind_q == SCAN_POST) begin
			if (!rd_s1.side) begin
				if (!bb_v_q || rd_s1.price > bb_price_q) begin
					bb_v_q     <= 1'b1;
					bb_price_q <= rd_s1.price;
					bb_total_q <= rd_s1.size;
					bb_cnt_q   <= CNT_W'(1);
				end else if (rd_s1.price == bb_price_q) begin
					bb_total_q <= sat_add(bb_total_q, rd_s1.size);
					if (bb_cnt_q != CNT_SAT) bb_cnt_q <= bb_cnt_q + CNT_W'(1);
				end
			end else begin
				if (!ba_v_q || rd_s1.price < ba_price_q) begin
					ba_v_q     <= 1'b1;
					ba_price_q <= rd_s1.price;
					ba_total_q <= rd_s1.size;
					ba_cnt_q   <= CNT_W'(1);
				end else if (rd_s1.price == ba_price_q) begin
					ba_total_q <= sat_add(ba_total_q, rd_s1.size);
					if (ba_cnt_q != CNT_SAT) ba_cnt_q <= ba_cnt_q + CNT_W'(1);
				end
			end
			if (o_found_q && idx_s1 != o_idx_q && rd_s1.side == o_side_q &&
			    rd_s1.price == o_price_q && age_e > age_o) begin
				qa_q <= sat_add(qa_q, rd_s1.size);
			end
		end

		if (cmd.emit) begin
			status      <= status_q;
			bid_valid   <= bb_v_q;
			bid_price   <= bb_price_q;
			bid_total   <= bb_total_q;
			bid_orders  <= bb_cnt_q;
			ask_valid   <= ba_v_q;
			ask_price   <= ba_price_q;
			ask_total   <= ba_total_q;
			ask_orders  <= ba_cnt_q;
			queue_ahead <= qa_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/order_book_mbo_update_unit.sv
`timescale 1ns / 1ps
// Top level of the market-by-order book update unit; joins obmu_ctrl and obmu_dpath.
// Each event first scans the order table for its order, a free slot and its price level;
// a modify that moves price scans again for the old level, and a clear then sweeps the table.
// A final scan builds best bid, best ask and queue ahead. A new event is accepted only after the
// last result is emitted; each scans the order table at least twice through its single read port.
// After reset the table is swept while in_stall stays high.
module order_book_mbo_update_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic [63:0]        order_ref,
	input  logic               side,
	input  logic signed [63:0] price,
	input  logic [31:0]        quantity,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic               bid_valid,
	output logic signed [63:0] bid_price,
	output logic [31:0]        bid_total,
	output logic [10:0]        bid_orders,
	output logic               ask_valid,
	output logic signed [63:0] ask_price,
	output logic [31:0]        ask_total,
	output logic [10:0]        ask_orders,
	output logic [31:0]        queue_ahead
);
	import obmu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	obmu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	obmu_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.order_ref   (order_ref),
		.side        (side),
		.price       (price),
		.quantity    (quantity),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.bid_valid   (bid_valid),
		.bid_price   (bid_price),
		.bid_total   (bid_total),
		.bid_orders  (bid_orders),
		.ask_valid   (ask_valid),
		.ask_price   (ask_price),
		.ask_total   (ask_total),
		.ask_orders  (ask_orders),
		.queue_ahead (queue_ahead)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	a_emit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("result not presented after emit");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.apply, cmd.emit}))
		else $error("overlapping controller commands");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= STS_FULL)
		else $error("status code out of range");

endmodule
